// File: src/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check on the block clock.
`define HVN_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hvn assertion failed");

// Follow-up check that post holds in the cycle after pre.
`define HVN_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hvn assertion failed");

`endif

// File: src/hvn_pkg.sv
package hvn_pkg;

  localparam int GRID_COLUMNS = 256;
  localparam int GRID_ROWS    = 256;
  localparam int COL_W        = $clog2(GRID_COLUMNS);
  localparam int ROW_W        = $clog2(GRID_ROWS);
  localparam int ADDR_W       = $clog2(GRID_COLUMNS * GRID_ROWS);

  localparam int HEIGHT_W  = 24;
  localparam int SPACING_W = 16;
  localparam int VEC_W     = 44;
  localparam int MAG_W     = 44;
  localparam int RES_W     = 32;

  localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd2560;
  localparam logic [14:0]          NORMAL_UP     = 15'd16384;

  localparam logic ACTION_WRITE  = 1'b0;
  localparam logic ACTION_QUERY  = 1'b1;
  localparam logic REG_SPACING_X = 1'b0;
  localparam logic REG_SPACING_Z = 1'b1;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV, N_DONE
  } norm_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_READ, T_FACE, T_START, T_WAIT, T_FSTART, T_FWAIT, T_PUT
  } top_state_t;

  typedef struct packed {
    logic start;
    logic final_pass;
  } norm_req_t;

  typedef struct packed {
    logic done;
    logic zero;
  } norm_rsp_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [RES_W-1:0] x;
    logic signed [RES_W-1:0] y;
    logic signed [RES_W-1:0] z;
  } res_t;

endpackage

// File: src/hvn_norm.sv
`include "assert_macros.svh"

module hvn_norm import hvn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  norm_req_t req,
  input  vec_t      vec,
  output norm_rsp_t rsp,
  output res_t      res
);

  norm_state_t state, state_next;

  logic [MAG_W-1:0] mag [3];
  logic             neg [3];
  logic             final_pass;
  logic             zero;
  logic [63:0]      sumsq;
  logic [63:0]      srem;
  logic [63:0]      root;
  logic [63:0]      bitv;
  logic [31:0]      len;
  logic [5:0]       cnt;
  logic [31:0]      drem [3];
  logic [30:0]      dnum [3];
  logic [30:0]      quo  [3];

  logic [MAG_W-1:0] in_mag [3];
  logic             in_neg [3];
  logic [MAG_W-1:0] top;
  logic [59:0]      sq;
  logic [63:0]      sumsq_next;
  logic [63:0]      trial;
  logic [63:0]      srem_next;
  logic [63:0]      root_next;
  logic [29:0]      sq_src;

  always_comb begin
    in_neg[0] = vec.x[VEC_W-1];
    in_neg[1] = vec.y[VEC_W-1];
    in_neg[2] = vec.z[VEC_W-1];
    in_mag[0] = in_neg[0] ? MAG_W'(-vec.x) : MAG_W'(vec.x);
    in_mag[1] = in_neg[1] ? MAG_W'(-vec.y) : MAG_W'(vec.y);
    in_mag[2] = in_neg[2] ? MAG_W'(-vec.z) : MAG_W'(vec.z);
  end

  always_comb begin
    top = mag[0];
    if (mag[1] > top) begin
      top = mag[1];
    end
    if (mag[2] > top) begin
      top = mag[2];
    end
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    sq_src = mag[0][29:0];
      2'd1:    sq_src = mag[1][29:0];
      default: sq_src = mag[2][29:0];
    endcase
    sq         = sq_src * sq_src;
    sumsq_next = sumsq + 64'(sq);
  end

  always_comb begin
    trial = root + bitv;
    if (srem >= trial) begin
      srem_next = srem - trial;
      root_next = (root >> 1) + bitv;
    end else begin
      srem_next = srem;
      root_next = root >> 1;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      N_IDLE: begin
        if (req.start) begin
          if (in_mag[0] == '0 && in_mag[1] == '0 && in_mag[2] == '0) begin
            state_next = N_DONE;
          end else begin
            state_next = N_SHIFT;
          end
        end
      end
      N_SHIFT: begin
        if (top[MAG_W-1:30] == '0 && top[29]) begin
          state_next = N_SQ;
        end
      end
      N_SQ: begin
        if (cnt[1:0] == 2'd2) begin
          state_next = N_SQRT;
        end
      end
      N_SQRT: begin
        if (bitv[0]) begin
          state_next = N_DIV;
        end
      end
      N_DIV: begin
        if (cnt == 6'd31) begin
          state_next = N_DONE;
        end
      end
      N_DONE:  state_next = N_IDLE;
      default: state_next = N_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done = (state == N_DONE);
    rsp.zero = zero;
    res.x = neg[0] ? -RES_W'(quo[0]) : RES_W'(quo[0]);
    res.y = neg[1] ? -RES_W'(quo[1]) : RES_W'(quo[1]);
    res.z = neg[2] ? -RES_W'(quo[2]) : RES_W'(quo[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= N_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    logic [60:0] num;
    logic [32:0] t;
    case (state)
      N_IDLE: begin
        if (req.start) begin
          final_pass <= req.final_pass;
          zero <= (in_mag[0] == '0 && in_mag[1] == '0 && in_mag[2] == '0);
          for (int i = 0; i < 3; i++) begin
            mag[i] <= in_mag[i];
            neg[i] <= in_neg[i];
            quo[i] <= '0;
          end
        end
      end
      N_SHIFT: begin
        if (top[MAG_W-1:30] != '0) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end else if (!top[29]) begin
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] << 1;
          end
        end else begin
          sumsq <= '0;
          cnt   <= '0;
        end
      end
      N_SQ: begin
        sumsq <= sumsq_next;
        cnt   <= cnt + 6'd1;
        if (cnt[1:0] == 2'd2) begin
          srem <= sumsq_next;
          root <= '0;
          bitv <= 64'd1 << 62;
        end
      end
      N_SQRT: begin
        srem <= srem_next;
        root <= root_next;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          len <= root_next[31:0];
          cnt <= '0;
        end
      end
      N_DIV: begin
        cnt <= cnt + 6'd1;
        for (int i = 0; i < 3; i++) begin
          if (cnt == '0) begin
            if (final_pass) begin
              num = 61'({mag[i][29:0], 14'd0}) + 61'(len >> 1);
            end else begin
              num = 61'({mag[i][29:0], 30'd0}) + 61'(len >> 1);
            end
            drem[i] <= 32'(num[60:31]);
            dnum[i] <= num[30:0];
          end else begin
            num = '0;
          end
          t = {drem[i], dnum[i][30]};
          if (cnt != '0) begin
            if (t >= {1'b0, len}) begin
              drem[i] <= 32'(t - {1'b0, len});
              quo[i]  <= {quo[i][29:0], 1'b1};
            end else begin
              drem[i] <= t[31:0];
              quo[i]  <= {quo[i][29:0], 1'b0};
            end
            dnum[i] <= dnum[i] << 1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  `HVN_ASSERT(a_start_idle, req.start |-> (state == N_IDLE))
  `HVN_ASSERT_NEXT(a_done_once, state == N_DONE, state == N_IDLE)
  `HVN_ASSERT(a_sq_range, (state == N_SQ) |-> (top[MAG_W-1:30] == '0 && top[29]))

endmodule

// File: src/heightmap_vertex_normals.sv
// Height-grid vertex normal unit. A write item (action 0) stores one Q15.8 height
// in the wrapped GRID_COLUMNS x GRID_ROWS grid; it gives no result. A query item
// (action 1) reads the cell's height and its six neighbors from the height
// memory's read port, then runs the six triangle normals and the final sum
// through one shared normalizer (range shift one bit a cycle, three squares,
// 32-step square root, divide for all three components). The range shift takes
// at most 29 one-bit steps per pass. A query holds in_ready low until its result
// is loaded into the output registers, and that load waits while an earlier
// result is held by out_ready.
// Heights of never-written entries are undefined; query only written areas.
// The column and row spacings sit at APB byte addresses 0 and 4.
`include "assert_macros.svh"

module heightmap_vertex_normals import hvn_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        action,
  input  logic [7:0]                  column,
  input  logic [7:0]                  row,
  input  logic signed [HEIGHT_W-1:0]  height,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          normal_x,
  output logic [14:0]                 normal_y,
  output logic signed [15:0]          normal_z,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  function automatic logic [COL_W-1:0] col_wrap(input logic [7:0] v);
    logic [19:0] rem;
    rem = 20'(v);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= 20'(GRID_COLUMNS << k)) begin
        rem = rem - 20'(GRID_COLUMNS << k);
      end
    end
    return COL_W'(rem);
  endfunction

  function automatic logic [ROW_W-1:0] row_wrap(input logic [7:0] v);
    logic [19:0] rem;
    rem = 20'(v);
    for (int k = 7; k >= 0; k--) begin
      if (rem >= 20'(GRID_ROWS << k)) begin
        rem = rem - 20'(GRID_ROWS << k);
      end
    end
    return ROW_W'(rem);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] cc,
                                                  input logic [ROW_W-1:0] rr);
    return ADDR_W'(rr) * ADDR_W'(GRID_COLUMNS) + ADDR_W'(cc);
  endfunction

  function automatic logic signed [24:0] hdiff(input logic signed [HEIGHT_W-1:0] a,
                                                input logic signed [HEIGHT_W-1:0] b);
    return {a[HEIGHT_W-1], a} - {b[HEIGHT_W-1], b};
  endfunction

  top_state_t state, state_next;

  logic [HEIGHT_W-1:0] mem [GRID_COLUMNS * GRID_ROWS];
  logic [HEIGHT_W-1:0] rdata;
  logic [ADDR_W-1:0]   raddr;

  logic [SPACING_W-1:0] pitch_x;
  logic [SPACING_W-1:0] pitch_z;

  logic [COL_W-1:0] c, cm, cp;
  logic [ROW_W-1:0] r, rm, rp;
  logic [COL_W-1:0] in_c;
  logic [ROW_W-1:0] in_r;
  logic [2:0]       cnt;
  logic [2:0]       fidx;
  logic signed [HEIGHT_W-1:0] h [7];
  vec_t             vec;
  vec_t             acc;
  vec_t             vec_next;
  vec_t             norm_vec;

  norm_req_t req;
  norm_rsp_t rsp;
  res_t      res;

  logic in_fire;
  logic capture;
  logic load_out;
  logic cfg_wr;

  logic               first;
  logic signed [24:0] da, db;
  logic signed [41:0] pa, pb;
  logic signed [41:0] sz_ext, sx_ext, da_ext, db_ext;
  logic [31:0]        pxz;

  assign in_fire = in_valid && in_ready;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign prdata  = (paddr[2] == REG_SPACING_Z) ? 32'(pitch_z) : 32'(pitch_x);
  assign in_c    = col_wrap(column);
  assign in_r    = row_wrap(row);

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_x <= SPACING_RESET;
      pitch_z <= SPACING_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_SPACING_X) begin
        pitch_x <= pwdata[SPACING_W-1:0];
      end else begin
        pitch_z <= pwdata[SPACING_W-1:0];
      end
    end
  end

  always_comb begin
    case (cnt)
      3'd0:    raddr = cell_addr(c,  r);
      3'd1:    raddr = cell_addr(c,  rp);
      3'd2:    raddr = cell_addr(cp, rp);
      3'd3:    raddr = cell_addr(cp, r);
      3'd4:    raddr = cell_addr(c,  rm);
      3'd5:    raddr = cell_addr(cm, rm);
      default: raddr = cell_addr(cm, r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_fire && action == ACTION_WRITE) begin
      mem[cell_addr(in_c, in_r)] <= height;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

  // face edge differences
  always_comb begin
    first = 1'b0;
    da    = '0;
    db    = '0;
    case (fidx)
      3'd0: begin first = 1'b1; da = hdiff(h[1], h[2]); db = hdiff(h[1], h[0]); end
      3'd1: begin first = 1'b1; da = hdiff(h[0], h[3]); db = hdiff(h[0], h[4]); end
      3'd2: begin first = 1'b1; da = hdiff(h[6], h[0]); db = hdiff(h[6], h[5]); end
      3'd3: begin first = 1'b0; da = hdiff(h[3], h[0]); db = hdiff(h[3], h[2]); end
      3'd4: begin first = 1'b0; da = hdiff(h[0], h[6]); db = hdiff(h[0], h[1]); end
      3'd5: begin first = 1'b0; da = hdiff(h[4], h[5]); db = hdiff(h[4], h[0]); end
      default: begin
      end
    endcase
    sz_ext = 42'(pitch_z);
    sx_ext = 42'(pitch_x);
    da_ext = 42'(da);
    db_ext = 42'(db);
    pa     = sz_ext * da_ext;
    pb     = sx_ext * db_ext;
    pxz    = pitch_x * pitch_z;
    vec_next.x = first ? VEC_W'(pa) : -VEC_W'(pa);
    vec_next.y = VEC_W'(pxz);
    vec_next.z = first ? -VEC_W'(pb) : VEC_W'(pb);
  end

  assign norm_vec = (state == T_FSTART) ? acc : vec;

  hvn_norm u_norm (
    .clk (clk),
    .rst (rst),
    .req (req),
    .vec (norm_vec),
    .rsp (rsp),
    .res (res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      T_IDLE: begin
        if (in_fire && action == ACTION_QUERY) begin
          state_next = T_READ;
        end
      end
      T_READ: begin
        if (cnt == 3'd7) begin
          state_next = T_FACE;
        end
      end
      T_FACE:  state_next = T_START;
      T_START: state_next = T_WAIT;
      T_WAIT: begin
        if (rsp.done) begin
          state_next = (fidx == 3'd5) ? T_FSTART : T_FACE;
        end
      end
      T_FSTART: state_next = T_FWAIT;
      T_FWAIT: begin
        if (rsp.done) begin
          state_next = T_PUT;
        end
      end
      T_PUT: begin
        if (!out_valid || out_ready) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready       = (state == T_IDLE);
    capture        = (state == T_READ) && (cnt != 3'd0);
    load_out       = (state == T_PUT) && (!out_valid || out_ready);
    req.start      = (state == T_START) || (state == T_FSTART);
    req.final_pass = (state == T_FSTART);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      c    <= in_c;
      r    <= in_r;
      cp   <= (in_c == COL_W'(GRID_COLUMNS - 1)) ? '0 : in_c + COL_W'(1);
      cm   <= (in_c == '0) ? COL_W'(GRID_COLUMNS - 1) : in_c - COL_W'(1);
      rp   <= (in_r == ROW_W'(GRID_ROWS - 1)) ? '0 : in_r + ROW_W'(1);
      rm   <= (in_r == '0) ? ROW_W'(GRID_ROWS - 1) : in_r - ROW_W'(1);
      cnt  <= '0;
      fidx <= '0;
      acc  <= '0;
    end
    if (state == T_READ) begin
      cnt <= cnt + 3'd1;
    end
    if (capture) begin
      h[6] <= rdata;
      for (int i = 0; i < 6; i++) begin
        h[i] <= h[i+1];
      end
    end
    if (state == T_FACE) begin
      vec <= vec_next;
    end
    if (state == T_WAIT && rsp.done) begin
      acc.x <= acc.x + VEC_W'(res.x);
      acc.y <= acc.y + VEC_W'(res.y);
      acc.z <= acc.z + VEC_W'(res.z);
      fidx  <= fidx + 3'd1;
    end
    if (load_out) begin
      if (rsp.zero) begin
        normal_x <= '0;
        normal_y <= NORMAL_UP;
        normal_z <= '0;
      end else begin
        normal_x <= res.x[15:0];
        normal_y <= res.y[14:0];
        normal_z <= res.z[15:0];
      end
    end
  end

  `HVN_ASSERT(a_done_in_wait, rsp.done |-> (state == T_WAIT || state == T_FWAIT))
  `HVN_ASSERT(a_up_bound, out_valid |-> (normal_y <= NORMAL_UP))
  `HVN_ASSERT_NEXT(a_query_reads, in_valid && in_ready && action == ACTION_QUERY, state == T_READ)

endmodule
